@@ rtl/core/stq_pkg.sv @@
// Shared types, codes and helpers of the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;

   localparam int IdW     = 27;
   localparam int TimeW   = 52;
   localparam int PeriodW = 40;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_POLL   = 2'd2;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_BAD_ID  = 2'd2;
   localparam logic [1:0] STS_NOT_DUE = 2'd3;

   typedef struct packed {
      logic [IdW-1:0]     id;
      logic [TimeW-1:0]   due;
      logic [PeriodW-1:0] period;
   } entry_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IdW-1:0]   id;
      logic             more_due;
      logic [TimeW-1:0] next_due;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ID_RD,
      ST_ID_CK,
      ST_POS_RD,
      ST_POS_CK,
      ST_SHU_RD,
      ST_SHU_WR,
      ST_FIND_RD,
      ST_FIND_CK,
      ST_POLL_WT,
      ST_SHD_RD,
      ST_SHD_WR,
      ST_HEAD_RD,
      ST_HEAD_WT,
      ST_DONE
   } state_type;

   // Saturating add of a time and a 40-bit offset.
   function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                 input logic [PeriodW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {{(TimeW + 1 - PeriodW){1'b0}}, b};
      sat_add = s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
   endfunction

endpackage

@@ rtl/core/stq_mem.sv @@
// Timer table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module stq_mem
   import stq_pkg::*;
#(
   parameter int TIMERS = 128
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [$clog2(TIMERS)-1:0] rd_addr,
   output entry_type                 rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(TIMERS)-1:0] wr_addr,
   input  entry_type                 wr_data
);

   entry_type mem [TIMERS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/stq_ctrl.sv @@
// Sequencer: identifier search, sorted insert, removal and head tracking.
`timescale 1ns / 1ps
module stq_ctrl
   import stq_pkg::*;
#(
   parameter int TIMERS   = 128,
   parameter int ID_LIMIT = 100000000
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [TimeW-1:0]          req_now,
   input  logic [PeriodW-1:0]        req_start,
   input  logic [PeriodW-1:0]        req_interval,
   input  logic [IdW-1:0]            req_target,
   input  logic                      rsp_free,
   output logic                      done,
   output result_type                result,
   output logic                      rd_en,
   output logic [$clog2(TIMERS)-1:0] rd_addr,
   input  entry_type                 rd_data,
   output logic                      wr_en,
   output logic [$clog2(TIMERS)-1:0] wr_addr,
   output entry_type                 wr_data
);

   localparam int AW = $clog2(TIMERS);
   localparam int CW = $clog2(TIMERS + 1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IdW-1:0]     idctr_ff, idctr_in;
   logic [TimeW-1:0]   head_ff, head_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [1:0]         op_ff, op_in;
   logic [TimeW-1:0]   now_ff, now_in;
   logic [IdW-1:0]     target_ff, target_in;
   logic [IdW-1:0]     nid_ff, nid_in;
   logic [TimeW-1:0]   nt_ff, nt_in;
   logic [PeriodW-1:0] np_ff, np_in;
   logic [1:0]         status_ff, status_in;
   logic [IdW-1:0]     rid_ff, rid_in;
   logic [IdW-1:0]     idctr_next;
   logic [CW-1:0]      idx_dec;

   assign idctr_next = (idctr_ff == IdW'(ID_LIMIT)) ? IdW'(1) : idctr_ff + IdW'(1);
   assign idx_dec    = idx_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idctr_ff <= IdW'(1);
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idctr_ff <= idctr_in;
         head_ff  <= head_in;
      end
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      op_ff     <= op_in;
      now_ff    <= now_in;
      target_ff <= target_in;
      nid_ff    <= nid_in;
      nt_ff     <= nt_in;
      np_ff     <= np_in;
      status_ff <= status_in;
      rid_ff    <= rid_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idctr_in  = idctr_ff;
      head_in   = head_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      op_in     = op_ff;
      now_in    = now_ff;
      target_in = target_ff;
      nid_in    = nid_ff;
      nt_in     = nt_ff;
      np_in     = np_ff;
      status_in = status_ff;
      rid_in    = rid_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '{id: nid_ff, due: nt_ff, period: np_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_kind;
               now_in    = req_now;
               target_in = req_target;
               rid_in    = '0;
               idx_in    = '0;
               state_in  = ST_DONE;
               if (req_kind == REQ_ADD) begin
                  if (count_ff == CW'(TIMERS) || 32'(count_ff) >= 32'(ID_LIMIT)) begin
                     status_in = STS_FULL;
                  end else begin
                     nid_in    = idctr_ff;
                     idctr_in  = idctr_next;
                     nt_in     = sat_add(req_now, req_start);
                     np_in     = req_interval;
                     status_in = STS_OK;
                     state_in  = ST_ID_RD;
                  end
               end else if (req_kind == REQ_DELETE) begin
                  status_in = STS_BAD_ID;
                  if (req_target != '0 && 32'(req_target) <= 32'(ID_LIMIT)) begin
                     state_in = ST_FIND_RD;
                  end
               end else if (req_kind == REQ_POLL) begin
                  if (count_ff == '0 || req_now < head_ff) begin
                     status_in = STS_NOT_DUE;
                  end else begin
                     status_in = STS_OK;
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     state_in  = ST_POLL_WT;
                  end
               end else begin
                  status_in = STS_BAD_ID;
               end
            end
         end
         ST_ID_RD: begin
            if (idx_ff == count_ff) begin
               rid_in   = nid_ff;
               idx_in   = '0;
               state_in = ST_POS_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_ID_CK;
            end
         end
         ST_ID_CK: begin
            // Candidate taken: try the next one from the start of the table.
            if (rd_data.id == nid_ff) begin
               nid_in   = idctr_ff;
               idctr_in = idctr_next;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
            state_in = ST_ID_RD;
         end
         ST_POS_RD: begin
            if (idx_ff == count_ff) begin
               pos_in   = count_ff;
               state_in = ST_SHU_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_POS_CK;
            end
         end
         ST_POS_CK: begin
            if (rd_data.due <= nt_ff) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_POS_RD;
            end else begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = ST_SHU_RD;
            end
         end
         ST_SHU_RD: begin
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               count_in = count_ff + CW'(1);
               state_in = ST_HEAD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[AW-1:0];
               state_in = ST_SHU_WR;
            end
         end
         ST_SHU_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_dec;
            state_in = ST_SHU_RD;
         end
         ST_FIND_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_FIND_CK;
            end
         end
         ST_FIND_CK: begin
            if (rd_data.id == target_ff) begin
               status_in = STS_OK;
               idx_in    = idx_ff + CW'(1);
               state_in  = ST_SHD_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_FIND_RD;
            end
         end
         ST_POLL_WT: begin
            rid_in   = rd_data.id;
            nid_in   = rd_data.id;
            np_in    = rd_data.period;
            nt_in    = sat_add(rd_data.due, rd_data.period);
            idx_in   = CW'(1);
            state_in = ST_SHD_RD;
         end
         ST_SHD_RD: begin
            if (idx_ff == count_ff) begin
               count_in = count_ff - CW'(1);
               idx_in   = '0;
               // Periodic timer: re-insert it after equal times.
               if (op_ff == REQ_POLL && np_ff != '0) begin
                  state_in = ST_POS_RD;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_SHD_WR;
            end
         end
         ST_SHD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_dec[AW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SHD_RD;
         end
         ST_HEAD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_HEAD_WT;
         end
         ST_HEAD_WT: begin
            head_in  = (count_ff != '0) ? rd_data.due : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result = '{status:   status_ff,
                     id:       rid_ff,
                     more_due: (count_ff != '0) && (now_ff >= head_ff),
                     next_due: (count_ff != '0) ? head_ff : '0};

endmodule

@@ rtl/core/sorted_timer_queue_top.sv @@
// Sorted timer queue: top level with stream ports and response register.
`timescale 1ns / 1ps
// A request walks the table entry by entry through the single memory read port; a delete or
// a one-shot poll walks it once, a periodic poll shifts entries out and then re-inserts, and
// an add rescans the table for each skipped id before it finds its place and shifts.
// Throughput: one request at a time; the next beat is taken once the sequencer is idle,
// even while the previous response still waits in the output register.
// Reset: synchronous, active high; clears the count, head time and id counter (to one).
module sorted_timer_queue_top
   import stq_pkg::*;
#(
   parameter int TIMERS   = 128,
   parameter int ID_LIMIT = 100000000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [51:0] now_us, [91:52] start_us, [131:92] interval_us, [158:132] target_id, [159] zero
   input  logic [159:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [26:0] result_id, [27] more_due, [79:28] next_due_us
   output logic [79:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser
);

   localparam int AW = $clog2(TIMERS);

   logic          rd_en, wr_en, done, rsp_free;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     rd_data, wr_data;
   result_type    result;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff;

   // The response slot frees up in the same cycle its beat is taken.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   stq_mem #(.TIMERS(TIMERS)) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   stq_ctrl #(.TIMERS(TIMERS), .ID_LIMIT(ID_LIMIT)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_now      (req_tdata[51:0]),
      .req_start    (req_tdata[91:52]),
      .req_interval (req_tdata[131:92]),
      .req_target   (req_tdata[158:132]),
      .rsp_free     (rsp_free),
      .done         (done),
      .result       (result),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   // Hold the response until the sink takes it; load a new one when the sequencer finishes.
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.next_due, rsp_ff.more_due, rsp_ff.id};

endmodule

@@ rtl/core/stq_checker.sv @@
// Port-level checks on the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps
module stq_checker
   import stq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_full_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_FULL |-> rsp_tdata[26:0] == '0)
      else $error("full response carries an id");

   a_idle_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STS_NOT_DUE || rsp_tuser == STS_BAD_ID)
      |-> rsp_tdata[26:0] == '0)
      else $error("rejected request carries an id");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response right after reset");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/tb_top.sv @@
// Self-checking testbench of the sorted timer queue: stream stimulus against a software table.
`timescale 1ns / 1ps
module tb_top;
   import stq_pkg::*;

   localparam int NTIMERS  = 128;
   localparam int IDLIMIT  = 100000000;
   localparam int WATCHDOG = 200000;
   localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [51:0] now_us, [91:52] start_us, [131:92] interval_us, [158:132] target_id, [159] zero
   logic [159:0] req_tdata = '0;
   // [1:0] req_type
   logic [1:0]   req_tuser = REQ_POLL;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [26:0] result_id, [27] more_due, [79:28] next_due_us
   logic [79:0]  rsp_tdata;
   // [1:0] status
   logic [1:0]   rsp_tuser;

   sorted_timer_queue_top #(.TIMERS(NTIMERS), .ID_LIMIT(IDLIMIT)) dut (.*);

   always #4 clock = ~clock;

   // Software copy of the timer table, kept sorted by due time.
   entry_type      timers[$];
   logic [IdW-1:0] next_id;
   logic [TimeW-1:0] sim_now;   // running notion of time for the stimulus

   result_type expected_rsp[$];
   int  fail_count;
   int  idle_cycles;
   int  rsp_gap = 0;    // cycles left in a long receiver gap
   bit  hold_rsp;       // set while the receiver holds off for a long stretch
   bit  rsp_idle_on;    // random receiver gaps enabled
   bit  req_idle_on;

   function automatic int timer_pos(logic [IdW-1:0] id);
      foreach (timers[i]) if (timers[i].id == id) return i;
      return -1;
   endfunction

   function automatic logic [TimeW-1:0] add_sat(logic [TimeW-1:0] a, logic [PeriodW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {{(TimeW + 1 - PeriodW){1'b0}}, b};
      return s[TimeW] ? TIME_MAX : s[TimeW-1:0];
   endfunction

   // Insert after every entry with an equal or earlier due time.
   function automatic void place_timer(entry_type e);
      int p;
      p = 0;
      while (p < timers.size() && timers[p].due <= e.due) p++;
      timers.insert(p, e);
   endfunction

   // Advance the table by one request and return the result it gives.
   function automatic result_type queue_step(logic [1:0] kind, logic [TimeW-1:0] now,
                                             logic [PeriodW-1:0] start,
                                             logic [PeriodW-1:0] period,
                                             logic [IdW-1:0] target);
      result_type r;
      entry_type  e;
      int p;
      r = '0;
      r.status = STS_BAD_ID;
      if (kind == REQ_ADD) begin
         if (timers.size() >= NTIMERS || timers.size() >= IDLIMIT) begin
            r.status = STS_FULL;
         end else begin
            do begin
               e.id = next_id;
               next_id = (32'(next_id) + 1 > IDLIMIT) ? IdW'(1) : next_id + IdW'(1);
            end while (timer_pos(e.id) >= 0);
            e.due = add_sat(now, start);
            e.period = period;
            place_timer(e);
            r.status = STS_OK;
            r.id = e.id;
         end
      end else if (kind == REQ_DELETE) begin
         p = (target >= 1 && target <= IDLIMIT) ? timer_pos(target) : -1;
         if (p >= 0) begin
            timers.delete(p);
            r.status = STS_OK;
         end
      end else if (kind == REQ_POLL) begin
         if (timers.size() == 0 || now < timers[0].due) begin
            r.status = STS_NOT_DUE;
         end else begin
            e = timers[0];
            timers.delete(0);
            if (e.period != 0) begin
               e.due = add_sat(e.due, e.period);
               place_timer(e);
            end
            r.status = STS_OK;
            r.id = e.id;
         end
      end
      r.more_due = timers.size() != 0 && now >= timers[0].due;
      r.next_due = timers.size() != 0 ? timers[0].due : '0;
      return r;
   endfunction

   // Send one beat and record its expected result at acceptance.
   task automatic send_request(logic [1:0] kind, logic [TimeW-1:0] now,
                               logic [PeriodW-1:0] start, logic [PeriodW-1:0] period,
                               logic [IdW-1:0] target);
      int gap;
      // Leave a gap before each beat, so valid drops after each one.
      gap = 1;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
      end
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, target, period, start, now};
      do @(posedge clock); while (!req_tready);
      expected_rsp.insert(expected_rsp.size(), queue_step(kind, now, start, period, target));
      req_tvalid <= 1'b0;
   endtask

   // Pause the sender until every expected result has come back.
   task automatic drain;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * NTIMERS + 20) @(posedge clock);
   endtask

   // Receiver: random tready with occasional long gaps, long hold-off on request.
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else if (!rsp_idle_on) rsp_tready <= 1'b1;
      else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (rsp_tvalid && $urandom_range(0, 19) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= $urandom_range(20, 300);
      end else rsp_tready <= ($urandom_range(0, 9) != 0) ||
                             ($urandom_range(0, 3) == 0);
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
         end else begin
            exp_r = expected_rsp[0];
            expected_rsp.delete(0);
            if (rsp_tuser != exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_tuser); fail_count++;
            end
            if (rsp_tdata[26:0] != exp_r.id) begin
               $error("result_id exp %0d got %0d", exp_r.id, rsp_tdata[26:0]); fail_count++;
            end
            if (rsp_tdata[27] != exp_r.more_due) begin
               $error("more_due exp %0d got %0d", exp_r.more_due, rsp_tdata[27]);
               fail_count++;
            end
            if (rsp_tdata[79:28] != exp_r.next_due) begin
               $error("next_due_us exp %0d got %0d", exp_r.next_due, rsp_tdata[79:28]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [PeriodW-1:0] rand40;
      return {8'($urandom_range(0, 255)), $urandom()};
   endfunction

   function automatic logic [TimeW-1:0] rand52;
      return {20'($urandom_range(0, 1048575)), $urandom()};
   endfunction

   function automatic logic [IdW-1:0] some_live_id;
      return timers.size() ? timers[$urandom_range(0, timers.size() - 1)].id : IdW'(1);
   endfunction

   // Extremes of every field and each special case.
   task automatic test_directed;
      send_request(REQ_POLL, 0, 0, 0, 0);                      // poll on empty table
      send_request(REQ_DELETE, 0, 0, 0, 1);                    // delete absent id
      send_request(REQ_DELETE, 0, 0, 0, 0);                    // id zero
      send_request(REQ_DELETE, 0, 0, 0, IdW'(IDLIMIT + 1));    // id above limit
      send_request(REQ_DELETE, 0, 0, 0, '1);
      send_request(REQ_UNUSED, TIME_MAX, '1, '1, '1);          // unknown request type
      send_request(REQ_ADD, 100, 50, 0, 0);                    // one-shot
      send_request(REQ_ADD, 100, 50, 10, 0);                   // equal time, goes after
      send_request(REQ_ADD, TIME_MAX, '1, '1, '1);             // saturating due time
      send_request(REQ_ADD, 0, 0, 0, 0);
      send_request(REQ_POLL, 149, 0, 0, 0);                    // takes the timer due at zero
      send_request(REQ_POLL, 150, 0, 0, 0);
      send_request(REQ_POLL, 150, 0, 0, 0);
      send_request(REQ_POLL, 150, 0, 0, 0);                    // not yet due
      send_request(REQ_POLL, TIME_MAX, '1, '1, '1);            // saturating head
      send_request(REQ_POLL, TIME_MAX, 0, 0, 0);
      send_request(REQ_DELETE, 0, 0, 0, 2);
      send_request(REQ_DELETE, 0, 0, 0, 3);
      send_request(REQ_DELETE, 0, 0, 0, 3);
      send_request(REQ_POLL, TIME_MAX, 0, 0, 0);
      drain();
   endtask

   // Fill the table past its size with the receiver held off, so the block stalls.
   task automatic test_full_table;
      int hold;
      hold_rsp = 1'b1;
      fork
         begin
            hold = 3000;
            while (hold > 0) begin @(posedge clock); hold--; end
            hold_rsp = 1'b0;
         end
         repeat (NTIMERS + 4)
            send_request(REQ_ADD, sim_now, PeriodW'($urandom_range(0, 5000)),
                         PeriodW'($urandom_range(0, 1)), 0);
      join
      drain();
      send_request(REQ_DELETE, 0, 0, 0, some_live_id());
      send_request(REQ_ADD, sim_now, 7, 0, 0);                 // takes the freed slot
      send_request(REQ_ADD, sim_now, 7, 0, 0);                 // full again
      while (timers.size() > 0) begin
         if ($urandom_range(0, 1)) send_request(REQ_DELETE, 0, 0, 0, some_live_id());
         else send_request(REQ_POLL, TIME_MAX, 0, 0, 0);
      end
      drain();
   endtask

   // Mostly realistic traffic with a moving clock, some noise and extreme values.
   task automatic test_random(int count);
      int sel;
      logic [IdW-1:0] tgt;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         sim_now = add_sat(sim_now, PeriodW'($urandom_range(0, 300)));
         if (sel < 5) begin
            send_request(2'($urandom_range(0, 3)), rand52(), rand40(), rand40(),
                         IdW'($urandom()));
         end else if (sel < 40 && timers.size() < 40) begin
            send_request(REQ_ADD, sim_now, ($urandom_range(0, 9) == 0) ? rand40() :
                         PeriodW'($urandom_range(0, 2000)), ($urandom_range(0, 2)) ?
                         PeriodW'($urandom_range(0, 1500)) : PeriodW'(0), IdW'($urandom()));
         end else if (sel < 60) begin
            tgt = $urandom_range(0, 3) ? some_live_id() : IdW'($urandom_range(0, 200));
            send_request(REQ_DELETE, sim_now, rand40(), rand40(), tgt);
         end else begin
            send_request(REQ_POLL, sim_now, rand40(), rand40(), IdW'($urandom()));
         end
         if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
   endtask

   initial begin
      fail_count = 0;
      idle_cycles = 0;
      hold_rsp = 1'b0;
      rsp_idle_on = 1'b1;
      req_idle_on = 1'b1;
      next_id = 1;
      sim_now = 1000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      rsp_idle_on = 1'b0;
      req_idle_on = 1'b0;
      test_random(150);
      rsp_idle_on = 1'b1;
      req_idle_on = 1'b1;
      test_random(400);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
